FILE: sv/sliding_window_arq_sender_core_macros.svh
// Assertion macros shared by the sender core RTL.
// Depends on nothing; included by modules that assert.
`ifndef SLIDING_WINDOW_ARQ_SENDER_CORE_MACROS_SVH
`define SLIDING_WINDOW_ARQ_SENDER_CORE_MACROS_SVH
// Implication checked every clock outside reset.
`define SWA_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("implication failed");
// Next-cycle implication checked every clock outside reset.
`define SWA_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: sv/swarq_pkg.sv
// Package for the sliding-window ARQ sender core: codes, widths and the cell state type.
// Depends on nothing.
package swarq_pkg;
  localparam int SEQ_W = 6;
  localparam int TICK_W = 8;
  localparam int RETRY_W = 6;
  localparam int SLOTS = 64;

  localparam logic [1:0] KIND_SEND = 2'd0;
  localparam logic [1:0] KIND_ACK = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [2:0] EV_NEW = 3'd0;
  localparam logic [2:0] EV_RETX = 3'd1;
  localparam logic [2:0] EV_REFUSED = 3'd2;
  localparam logic [2:0] EV_ACK_OK = 3'd3;
  localparam logic [2:0] EV_ACK_IGN = 3'd4;
  localparam logic [2:0] EV_GIVE_UP = 3'd5;
  localparam logic [2:0] EV_HALTED = 3'd6;

  localparam logic [1:0] CFG_WINDOW = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_RETRIES = 2'd2;

  typedef struct packed {
    logic armed;
    logic [TICK_W-1:0] ticks;
    logic [RETRY_W-1:0] retry;
  } slot_t;

  typedef struct packed {
    logic clear;
    logic decr;
    logic shift;
  } cell_ctl_t;
endpackage

FILE: sv/swarq_cell.sv
// One slot cell of the rotating slot ring; holds armed flag, tick count and retry count.
// Depends on swarq_pkg.
module swarq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  swarq_pkg::cell_ctl_t ctl,
  input  logic                ld,
  input  swarq_pkg::slot_t    ld_val,
  input  swarq_pkg::slot_t    prev,
  output swarq_pkg::slot_t    q
);
  swarq_pkg::slot_t q_r, q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ctl.decr && q_r.armed && q_r.ticks != '0) begin
      q_nxt.ticks = q_r.ticks - 1'b1;
    end
    if (ctl.shift) begin
      q_nxt = prev;
    end
    if (ld) begin
      q_nxt = ld_val;
    end
    if (ctl.clear) begin
      q_nxt.armed = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.armed <= 1'b0;
    end else begin
      q_r.armed <= q_nxt.armed;
    end
    q_r.ticks <= q_nxt.ticks;
    q_r.retry <= q_nxt.retry;
  end

  assign q = q_r;
endmodule

FILE: sv/sliding_window_arq_sender_core.sv
// Sliding-window ARQ sender core: a ring of 64 slot cells, rotated one place per cycle while it shifts.
// Depends on swarq_pkg, swarq_cell and the macros header.
// Send, refused, ignored-ack and halted words come in the cycle after start; a send stays
// busy while the ring rotates, as do a window write, an accepted ack and a tick, and the
// ack's or tick's last word comes as busy drops. One item at a time; results never wait.
// Synchronous active-low reset sets control and config registers to defaults, disarms every slot.
`include "sliding_window_arq_sender_core_macros.svh"
module sliding_window_arq_sender_core #(
  parameter int MAX_WINDOW = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_kind,
  input  logic [5:0] in_ack_number,
  input  logic       in_ack_crc_ok,
  output logic       out_strobe,
  output logic [2:0] out_event_res,
  output logic [5:0] out_sequence_res,
  output logic [5:0] out_free_slots,
  output logic       out_window_full,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  localparam int N = swarq_pkg::SLOTS;
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ACK = 3'd1;
  localparam logic [2:0] ST_DECR = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_ALIGN = 3'd4;

  logic [2:0] st_r, st_nxt;
  logic [5:0] win_r, win_nxt;
  logic [7:0] tmo_r, tmo_nxt;
  logic [5:0] maxr_r, maxr_nxt;
  logic [5:0] lar_r, lar_nxt, lfs_r, lfs_nxt, avail_r, avail_nxt;
  logic gave_r, gave_nxt;
  // rot_r is the sequence number currently held in cell 0.
  logic [5:0] rot_r, rot_nxt;
  logic [5:0] tgt_r, tgt_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [6:0] nres_r, nres_nxt;
  logic stop_r, stop_nxt;
  logic o_stb_r, o_stb_nxt, o_last_r, o_last_nxt;
  logic [2:0] o_ev_r, o_ev_nxt;
  logic [5:0] o_seq_r, o_seq_nxt, o_free_r, o_free_nxt;
  // A scan word is held back until it is known whether another one follows.
  logic pv_r, pv_nxt;
  logic [2:0] p_ev_r, p_ev_nxt;
  logic [5:0] p_seq_r, p_seq_nxt;

  logic [5:0] w_eff;
  logic [6:0] s_sz;
  logic [7:0] t_eff;
  swarq_pkg::slot_t cq [N];
  swarq_pkg::slot_t ld_val;
  logic ld0;
  swarq_pkg::cell_ctl_t ctl;
  logic clr0;
  logic [5:0] nxt_seq, nxt_lar;
  logic [5:0] r_inc;
  logic inwin;

  always_comb begin
    w_eff = (win_r == '0) ? 6'd1 : win_r;
    if (32'(w_eff) > MAX_WINDOW) w_eff = 6'(MAX_WINDOW);
    if (w_eff > 6'd32) w_eff = 6'd32;
  end
  assign s_sz = {w_eff, 1'b0};
  assign t_eff = (tmo_r == '0) ? 8'd1 : tmo_r;

  function automatic logic [5:0] inc_mod(input logic [5:0] v, input logic [6:0] s);
    logic [6:0] t;
    t = {1'b0, v} + 7'd1;
    return (t >= s) ? 6'd0 : t[5:0];
  endfunction

  for (genvar g = 0; g < N; g++) begin : g_cell
    swarq_pkg::cell_ctl_t cell_ctl;
    assign cell_ctl = {((g == 0) ? clr0 : 1'b0), ctl.decr, ctl.shift};
    swarq_cell u_cell (
      .clk(clk), .rst_n(rst_n),
      .ctl(cell_ctl),
      .ld((g == 0) ? ld0 : 1'b0), .ld_val(ld_val),
      .prev(cq[(g + 1) % N]), .q(cq[g])
    );
  end

  always_comb begin
    st_nxt = st_r; win_nxt = win_r; tmo_nxt = tmo_r; maxr_nxt = maxr_r;
    lar_nxt = lar_r; lfs_nxt = lfs_r; avail_nxt = avail_r; gave_nxt = gave_r;
    rot_nxt = rot_r; tgt_nxt = tgt_r; cnt_nxt = cnt_r; nres_nxt = nres_r;
    stop_nxt = stop_r;
    o_stb_nxt = 1'b0; o_last_nxt = 1'b0; o_ev_nxt = o_ev_r; o_seq_nxt = o_seq_r;
    o_free_nxt = o_free_r;
    pv_nxt = pv_r; p_ev_nxt = p_ev_r; p_seq_nxt = p_seq_r;
    ctl = '0; ld0 = 1'b0; clr0 = 1'b0; ld_val = cq[0];
    nxt_seq = inc_mod(lfs_r, s_sz);
    nxt_lar = inc_mod(lar_r, s_sz);
    r_inc = (cq[0].retry == 6'd63) ? 6'd63 : cq[0].retry + 6'd1;
    if (lar_r <= lfs_r) inwin = (lar_r < in_ack_number) && (in_ack_number <= lfs_r);
    else inwin = (lar_r < in_ack_number) || (in_ack_number <= lfs_r);
    unique case (st_r)
      ST_IDLE: begin
        if (cfg_valid && cfg_ready) begin
          unique case (cfg_index)
            swarq_pkg::CFG_WINDOW: begin
              win_nxt = cfg_data[5:0];
              st_nxt = ST_ALIGN; cnt_nxt = '0; nres_nxt = '0; avail_nxt = '0;
              lar_nxt = '0; lfs_nxt = '0; gave_nxt = 1'b0;
            end
            swarq_pkg::CFG_TIMEOUT: tmo_nxt = cfg_data;
            swarq_pkg::CFG_RETRIES: maxr_nxt = cfg_data[5:0];
            default: ;
          endcase
        end else if (start && in_kind != swarq_pkg::KIND_NONE) begin
          o_free_nxt = avail_r;
          o_seq_nxt = '0;
          if (gave_r) begin
            o_stb_nxt = 1'b1; o_last_nxt = 1'b1; o_ev_nxt = swarq_pkg::EV_HALTED;
          end else if (in_kind == swarq_pkg::KIND_SEND) begin
            o_stb_nxt = 1'b1; o_last_nxt = 1'b1;
            if (avail_r == '0) begin
              o_ev_nxt = swarq_pkg::EV_REFUSED;
            end else begin
              o_ev_nxt = swarq_pkg::EV_NEW; o_seq_nxt = nxt_seq;
              lfs_nxt = nxt_seq; avail_nxt = avail_r - 6'd1; o_free_nxt = avail_r - 6'd1;
              tgt_nxt = nxt_seq; stop_nxt = 1'b0;
              st_nxt = ST_ALIGN; cnt_nxt = 7'd1;
            end
          end else if (in_kind == swarq_pkg::KIND_ACK) begin
            if (in_ack_crc_ok && {1'b0, in_ack_number} < s_sz && inwin) begin
              tgt_nxt = in_ack_number; st_nxt = ST_ACK;
            end else begin
              o_stb_nxt = 1'b1; o_last_nxt = 1'b1; o_ev_nxt = swarq_pkg::EV_ACK_IGN;
            end
          end else begin
            st_nxt = ST_DECR;
          end
        end
      end
      ST_ACK: begin
        // Rotate the ring until the freed slot sits in cell 0, then disarm it.
        if (rot_r == nxt_lar) begin
          clr0 = 1'b1;
          lar_nxt = nxt_lar;
          if (avail_r < w_eff) avail_nxt = avail_r + 6'd1;
          if (nxt_lar == tgt_r) begin
            st_nxt = ST_IDLE; o_stb_nxt = 1'b1; o_last_nxt = 1'b1;
            o_ev_nxt = swarq_pkg::EV_ACK_OK; o_seq_nxt = '0;
            o_free_nxt = (avail_r < w_eff) ? avail_r + 6'd1 : avail_r;
          end
        end else begin
          ctl.shift = 1'b1; rot_nxt = 6'(rot_r + 6'd1);
        end
      end
      ST_DECR: begin
        ctl.decr = 1'b1;
        st_nxt = ST_ALIGN; cnt_nxt = 7'd2; tgt_nxt = nxt_lar;
        nres_nxt = '0; stop_nxt = 1'b0;
      end
      ST_ALIGN: begin
        if (cnt_r == 7'd0) begin
          // Window reset: sweep the ring once, disarming every cell.
          clr0 = 1'b1; ctl.shift = 1'b1; rot_nxt = 6'(rot_r + 6'd1);
          nres_nxt = 7'(nres_r + 7'd1);
          if (nres_r == 7'd63) begin
            st_nxt = ST_IDLE; avail_nxt = w_eff;
          end
        end else if (rot_r != tgt_r) begin
          ctl.shift = 1'b1; rot_nxt = 6'(rot_r + 6'd1);
        end else if (cnt_r == 7'd1) begin
          ld0 = 1'b1;
          ld_val = '{armed: 1'b1, ticks: t_eff, retry: '0};
          st_nxt = ST_IDLE;
        end else begin
          st_nxt = ST_SCAN; cnt_nxt = s_sz;
        end
      end
      ST_SCAN: begin
        if (cnt_r == '0 || stop_r) begin
          st_nxt = ST_IDLE;
          if (pv_r) begin
            o_stb_nxt = 1'b1; o_last_nxt = 1'b1; o_ev_nxt = p_ev_r; o_seq_nxt = p_seq_r;
            o_free_nxt = avail_r; pv_nxt = 1'b0;
          end
        end else if ({1'b0, rot_r} >= s_sz) begin
          // Cells above the sequence space are passed over on the way back to zero.
          ctl.shift = 1'b1; rot_nxt = 6'(rot_r + 6'd1);
        end else if (cq[0].armed && cq[0].ticks == '0) begin
          ld0 = 1'b1;
          ld_val.retry = r_inc;
          nres_nxt = 7'(nres_r + 7'd1);
          pv_nxt = 1'b1; p_seq_nxt = rot_r;
          if (pv_r) begin
            o_stb_nxt = 1'b1; o_ev_nxt = p_ev_r; o_seq_nxt = p_seq_r; o_free_nxt = avail_r;
          end
          if (r_inc > maxr_r) begin
            p_ev_nxt = swarq_pkg::EV_GIVE_UP; gave_nxt = 1'b1; stop_nxt = 1'b1;
          end else begin
            ld_val.ticks = t_eff;
            p_ev_nxt = swarq_pkg::EV_RETX;
            if (nres_r == 7'd31) stop_nxt = 1'b1;
          end
        end else begin
          cnt_nxt = cnt_r - 7'd1;
          rot_nxt = 6'(rot_r + 6'd1);
          ctl.shift = 1'b1;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; win_r <= 6'd4; tmo_r <= 8'd3; maxr_r <= 6'd25;
      lar_r <= '0; lfs_r <= '0; avail_r <= 6'd4; gave_r <= 1'b0; rot_r <= '0;
      tgt_r <= '0; cnt_r <= '0; nres_r <= '0; stop_r <= 1'b0;
      o_stb_r <= 1'b0; o_last_r <= 1'b0; pv_r <= 1'b0;
    end else begin
      st_r <= st_nxt; win_r <= win_nxt; tmo_r <= tmo_nxt; maxr_r <= maxr_nxt;
      lar_r <= lar_nxt; lfs_r <= lfs_nxt; avail_r <= avail_nxt; gave_r <= gave_nxt;
      rot_r <= rot_nxt; tgt_r <= tgt_nxt; cnt_r <= cnt_nxt; nres_r <= nres_nxt;
      stop_r <= stop_nxt; o_stb_r <= o_stb_nxt; o_last_r <= o_last_nxt; pv_r <= pv_nxt;
    end
    o_ev_r <= o_ev_nxt; o_seq_r <= o_seq_nxt; o_free_r <= o_free_nxt;
    p_ev_r <= p_ev_nxt; p_seq_r <= p_seq_nxt;
  end

  assign busy = (st_r != ST_IDLE);
  assign cfg_ready = (st_r == ST_IDLE) && !start;
  assign out_strobe = o_stb_r;
  assign out_event_res = o_ev_r;
  assign out_sequence_res = o_seq_r;
  assign out_free_slots = o_free_r;
  assign out_window_full = (o_free_r == '0);
  assign out_last = o_last_r;

  `SWA_ASSERT_IMP(a_free_bound, clk, rst_n, 1'b1, avail_r <= w_eff)
  `SWA_ASSERT_IMP(a_last_strobe, clk, rst_n, out_last, out_strobe)
  `SWA_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy && in_kind == swarq_pkg::KIND_TICK && !gave_r, busy)
endmodule

FILE: dv/tb_sliding_window_arq_sender_core.sv
// Self-checking testbench for the sliding-window ARQ sender core: directed table, give-up check, then random.
// Depends on swarq_pkg and the sliding_window_arq_sender_core RTL.
module tb_sliding_window_arq_sender_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] ev;
    logic [5:0] seq;
    logic [5:0] free;
    logic       full;
    logic       last;
  } arq_word_t;

  typedef struct {
    logic [1:0] kind;
    logic [5:0] ackn;
    logic       crc;
    bit         has_exp;
    logic [2:0] exp_ev;
  } stim_row_t;

  logic clk, rst_n, start, busy;
  logic [1:0] in_kind;
  logic [5:0] in_ack_number;
  logic in_ack_crc_ok;
  logic out_strobe;
  logic [2:0] out_event_res;
  logic [5:0] out_sequence_res, out_free_slots;
  logic out_window_full, out_last;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  sliding_window_arq_sender_core DUT (.*);

  // Shadow copy of the sender state.
  logic [5:0] cfg_win, cfg_retries;
  logic [7:0] cfg_to;
  logic [5:0] lar, lfs, avail;
  logic armed[64];
  logic [7:0] ticks[64];
  logic [5:0] retries[64];
  bit halted;

  arq_word_t pending_words[$];
  int n_errors, n_words, n_items, n_retx, n_giveup;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [5:0] eff_win();
    if (cfg_win < 6'd1) return 6'd1;
    if (cfg_win > 6'd32) return 6'd32;
    return cfg_win;
  endfunction

  function automatic logic [7:0] eff_to();
    return (cfg_to == 8'd0) ? 8'd1 : cfg_to;
  endfunction

  function automatic void clear_sender();
    lar = 0; lfs = 0; avail = eff_win(); halted = 0;
    foreach (armed[i]) begin
      armed[i] = 0; ticks[i] = 0; retries[i] = 0;
    end
  endfunction

  function automatic void push_word(logic [2:0] ev, logic [5:0] seq);
    arq_word_t w;
    w.ev = ev; w.seq = seq; w.free = avail; w.full = (avail == 0); w.last = 0;
    pending_words.push_back(w);
  endfunction

  function automatic bit seq_in_window(int l, int r, int s);
    if (l <= r) return (l < s) && (s <= r);
    return (l < s) || (s <= r);
  endfunction

  function automatic void predict_sender(logic [1:0] kind, logic [5:0] ackn, logic crc);
    int sp, n, idx;
    arq_word_t w;
    sp = 2 * eff_win();
    n = 0;
    if (kind == swarq_pkg::KIND_NONE) return;
    if (halted) begin
      push_word(swarq_pkg::EV_HALTED, 6'd0);
      n = 1;
    end else if (kind == swarq_pkg::KIND_SEND) begin
      if (avail == 0) push_word(swarq_pkg::EV_REFUSED, 6'd0);
      else begin
        lfs = 6'((lfs + 1) % sp);
        armed[lfs] = 1; ticks[lfs] = eff_to(); retries[lfs] = 0;
        avail--;
        push_word(swarq_pkg::EV_NEW, lfs);
      end
      n = 1;
    end else if (kind == swarq_pkg::KIND_ACK) begin
      if (crc && ackn < sp && seq_in_window(lar, lfs, ackn)) begin
        while (lar != ackn) begin
          lar = 6'((lar + 1) % sp);
          armed[lar] = 0;
          if (avail < eff_win()) avail++;
        end
        push_word(swarq_pkg::EV_ACK_OK, 6'd0);
      end else push_word(swarq_pkg::EV_ACK_IGN, 6'd0);
      n = 1;
    end else begin
      for (int i = 0; i < sp; i++)
        if (armed[i] && ticks[i] > 0) ticks[i]--;
      idx = (lar + 1) % sp;
      for (int j = 0; j < sp && n < 32; j++) begin
        if (armed[idx] && ticks[idx] == 0) begin
          if (retries[idx] < 63) retries[idx]++;
          if (retries[idx] > cfg_retries) begin
            halted = 1;
            push_word(swarq_pkg::EV_GIVE_UP, 6'(idx));
            n++;
            n_giveup++;
            break;
          end
          ticks[idx] = eff_to();
          push_word(swarq_pkg::EV_RETX, 6'(idx));
          n++;
          n_retx++;
        end
        idx = (idx + 1) % sp;
      end
    end
    if (n > 0) begin
      w = pending_words.pop_back();
      w.last = 1;
      pending_words.push_back(w);
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    n_errors++;
  endtask

  always @(posedge clk) begin
    arq_word_t w;
    if (rst_n && out_strobe) begin
      n_words++;
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word, event", out_event_res, -1);
      end else begin
        w = pending_words.pop_front();
        if (out_event_res !== w.ev) report_mismatch("event", out_event_res, w.ev);
        if (out_sequence_res !== w.seq) report_mismatch("sequence", out_sequence_res, w.seq);
        if (out_free_slots !== w.free) report_mismatch("free_slots", out_free_slots, w.free);
        if (out_window_full !== w.full) report_mismatch("window_full", out_window_full, w.full);
        if (out_last !== w.last) report_mismatch("last", out_last, w.last);
      end
    end
  end

  task automatic idle_gap();
    if ($urandom_range(99) < 33) begin
      start <= 0;
      do @(negedge clk); while ($urandom_range(99) < 33);
    end
  endtask

  task automatic send_item(logic [1:0] kind, logic [5:0] ackn, logic crc, bit gaps);
    if (gaps) idle_gap();
    start <= 1; in_kind <= kind; in_ack_number <= ackn; in_ack_crc_ok <= crc;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_sender(kind, ackn, crc);
    n_items++;
    @(negedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start <= 0;
    while (pending_words.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (80) @(negedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [7:0] val);
    drain();
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == swarq_pkg::CFG_WINDOW) begin
      cfg_win = val[5:0];
      clear_sender();
    end else if (idx == swarq_pkg::CFG_TIMEOUT) cfg_to = val;
    else if (idx == swarq_pkg::CFG_RETRIES) cfg_retries = val[5:0];
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_phase(int count, bit gaps);
    int r;
    logic [5:0] a;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 40) send_item(swarq_pkg::KIND_SEND, 6'($urandom), 1'($urandom), gaps);
      else if (r < 65) begin
        a = (r < 58) ? 6'((lar + $urandom_range(1, 3)) % (2 * eff_win())) : 6'($urandom);
        send_item(swarq_pkg::KIND_ACK, a, (r < 62) ? 1'b1 : 1'($urandom), gaps);
      end else if (r < 97) send_item(swarq_pkg::KIND_TICK, 6'($urandom), 1'($urandom), gaps);
      else send_item(swarq_pkg::KIND_NONE, 6'($urandom), 1'($urandom), gaps);
    end
  endtask

  stim_row_t dir_rows[$];

  function automatic stim_row_t mk(logic [1:0] k, logic [5:0] a, logic c, bit h, logic [2:0] e);
    stim_row_t s;
    s.kind = k; s.ackn = a; s.crc = c; s.has_exp = h; s.exp_ev = e;
    return s;
  endfunction

  initial begin
    rst_n = 0; start = 0; in_kind = 0; in_ack_number = 0; in_ack_crc_ok = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    n_errors = 0; n_words = 0; n_items = 0; n_retx = 0; n_giveup = 0;
    cfg_win = 4; cfg_to = 3; cfg_retries = 25;
    clear_sender();
    repeat (11) @(negedge clk);
    rst_n = 1;

    dir_rows.push_back(mk(swarq_pkg::KIND_ACK, 6'd1, 1, 1, swarq_pkg::EV_ACK_IGN));
    dir_rows.push_back(mk(swarq_pkg::KIND_TICK, 6'd0, 0, 0, 0));
    for (int i = 0; i < 4; i++)
      dir_rows.push_back(mk(swarq_pkg::KIND_SEND, 6'd63, 1, 1, swarq_pkg::EV_NEW));
    dir_rows.push_back(mk(swarq_pkg::KIND_SEND, 6'd0, 0, 1, swarq_pkg::EV_REFUSED));
    dir_rows.push_back(mk(swarq_pkg::KIND_ACK, 6'd63, 1, 1, swarq_pkg::EV_ACK_IGN));
    dir_rows.push_back(mk(swarq_pkg::KIND_ACK, 6'd2, 0, 1, swarq_pkg::EV_ACK_IGN));
    dir_rows.push_back(mk(swarq_pkg::KIND_NONE, 6'd0, 1, 0, 0));
    dir_rows.push_back(mk(swarq_pkg::KIND_TICK, 6'd0, 0, 0, 0));
    dir_rows.push_back(mk(swarq_pkg::KIND_TICK, 6'd0, 0, 0, 0));
    dir_rows.push_back(mk(swarq_pkg::KIND_TICK, 6'd0, 0, 0, 0));
    dir_rows.push_back(mk(swarq_pkg::KIND_ACK, 6'd2, 1, 1, swarq_pkg::EV_ACK_OK));
    dir_rows.push_back(mk(swarq_pkg::KIND_ACK, 6'd4, 1, 1, swarq_pkg::EV_ACK_OK));
    dir_rows.push_back(mk(swarq_pkg::KIND_SEND, 6'd0, 0, 1, swarq_pkg::EV_NEW));
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].kind, dir_rows[i].ackn, dir_rows[i].crc, 0);
      if (dir_rows[i].has_exp && pending_words.size() > 0 &&
          pending_words[$].ev !== dir_rows[i].exp_ev)
        report_mismatch("directed event", pending_words[$].ev, dir_rows[i].exp_ev);
    end

    // Give up quickly, then check halted behavior.
    write_cfg(swarq_pkg::CFG_RETRIES, 8'd0);
    write_cfg(swarq_pkg::CFG_TIMEOUT, 8'd0);
    send_item(swarq_pkg::KIND_TICK, 6'd0, 1'b0, 0);
    send_item(swarq_pkg::KIND_TICK, 6'd0, 1'b0, 0);
    send_item(swarq_pkg::KIND_TICK, 6'd0, 1'b0, 0);
    send_item(swarq_pkg::KIND_SEND, 6'd0, 1'b0, 0);
    send_item(swarq_pkg::KIND_ACK, 6'd0, 1'b1, 0);

    write_cfg(swarq_pkg::CFG_WINDOW, 8'd32);
    write_cfg(swarq_pkg::CFG_TIMEOUT, 8'd2);
    write_cfg(swarq_pkg::CFG_RETRIES, 8'd63);
    random_phase(60, 0);
    write_cfg(swarq_pkg::CFG_WINDOW, 8'd0);
    write_cfg(swarq_pkg::CFG_TIMEOUT, 8'd255);
    random_phase(30, 1);
    write_cfg(swarq_pkg::CFG_WINDOW, 8'd63);
    write_cfg(swarq_pkg::CFG_TIMEOUT, 8'd1);
    write_cfg(swarq_pkg::CFG_RETRIES, 8'd3);
    random_phase(70, 1);
    write_cfg(swarq_pkg::CFG_WINDOW, 8'd5);
    write_cfg(swarq_pkg::CFG_TIMEOUT, 8'd3);
    write_cfg(swarq_pkg::CFG_RETRIES, 8'd6);
    random_phase(80, 1);
    write_cfg(swarq_pkg::CFG_WINDOW, 8'd1);
    write_cfg(swarq_pkg::CFG_TIMEOUT, 8'd2);
    write_cfg(swarq_pkg::CFG_RETRIES, 8'd62);
    random_phase(80, 1);
    drain();
    if (pending_words.size() != 0)
      report_mismatch("words still expected", pending_words.size(), 0);

    $display("Ran %0d items and checked %0d words, %0d retransmits, %0d give-ups.",
             n_items, n_words, n_retx, n_giveup);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
